@@ rtl/riplea_pkg.sv @@
// riplea_pkg: shared types, constants and status codes for the lea reference scanner
// used by riplea_match and rip_relative_lea_reference_scan; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package riplea_pkg;

   // address arithmetic width, wraps modulo 2^AddrWidth
   localparam int AddrWidth   = 48;
   localparam int FieldWidth  = 48;
   localparam int WindowDepth = 6;
   localparam int RunWidth    = $clog2(WindowDepth + 1);
   localparam int DispWidth   = 32;

   // instruction pattern
   localparam logic [7:0] PrefixRexW  = 8'h48;
   localparam logic [7:0] PrefixRexWR = 8'h4C;
   localparam logic [7:0] OpcodeLea   = 8'h8D;
   localparam logic [7:0] ModrmMask   = 8'hC7;
   localparam logic [7:0] ModrmRipRel = 8'h05;

   // configuration port
   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 64;
   localparam logic CsrTargetIdx = 1'b0;

   typedef enum logic [1:0] {
      StatusNone      = 2'd0,
      StatusUnique    = 2'd1,
      StatusAmbiguous = 2'd2
   } match_status_type;

   // window of held bytes, index 0 is the oldest
   typedef logic [WindowDepth-1:0][7:0] window_type;

   // one captured input word
   typedef struct packed {
      logic [7:0]           data_byte;
      logic [AddrWidth-1:0] byte_address;
      logic                 first_of_range;
      logic                 range_executable;
      logic                 last_of_scan;
   } word_type;

endpackage

`default_nettype wire

@@ rtl/riplea_match.sv @@
// riplea_match: decodes the seven-byte candidate and checks its rip-relative target
// depends on riplea_pkg
`timescale 1ns / 1ps
`default_nettype none

module riplea_match (
   input  wire riplea_pkg::window_type                window_bytes,
   input  wire logic [7:0]                            cur_byte,
   input  wire logic [riplea_pkg::AddrWidth-1:0]      cur_address,
   input  wire logic [riplea_pkg::AddrWidth-1:0]      target_address,
   output logic                                       hit
);

   logic                                  prefix_ok;
   logic                                  opcode_ok;
   logic                                  modrm_ok;
   logic [riplea_pkg::DispWidth-1:0]      disp;
   logic [riplea_pkg::AddrWidth-1:0]      disp_ext;
   logic [riplea_pkg::AddrWidth-1:0]      ref_address;

   // opcode pattern on the three oldest bytes
   always_comb begin
      prefix_ok = (window_bytes[0] == riplea_pkg::PrefixRexW) ||
                  (window_bytes[0] == riplea_pkg::PrefixRexWR);
      opcode_ok = (window_bytes[1] == riplea_pkg::OpcodeLea);
      modrm_ok  = ((window_bytes[2] & riplea_pkg::ModrmMask) == riplea_pkg::ModrmRipRel);
   end

   // little-endian displacement, sign extended
   assign disp     = {cur_byte, window_bytes[5], window_bytes[4], window_bytes[3]};
   assign disp_ext = {{(riplea_pkg::AddrWidth - riplea_pkg::DispWidth){disp[31]}}, disp};

   // next instruction address plus displacement, one adder with carry in
   assign ref_address = cur_address + disp_ext + riplea_pkg::AddrWidth'(1);

   assign hit = prefix_ok && opcode_ok && modrm_ok && (ref_address == target_address);

endmodule

`default_nettype wire

@@ rtl/rip_relative_lea_reference_scan.sv @@
// rip_relative_lea_reference_scan: top level of the lea reference scanner
// depends on riplea_pkg and riplea_match
`timescale 1ns / 1ps
`default_nettype none

// Scans a byte stream for 64-bit rip-relative lea instructions (rex.w 0x48 or
// 0x4c, opcode 0x8d, modrm rip-relative) whose computed target equals the
// target_address register (csr byte address 0, 64-bit data, low 48 bits used).
// One byte is taken per cycle with no bubbles while req_ready is high: the input
// register feeds one 48-bit add and compare and the window/count update in the
// same cycle. The report for a scan is loaded into an output register when its
// last byte advances out of the input register and is held until taken; req_ready
// drops only when a further last byte reaches the scan stage while that report
// has not yet been taken. Matches never span a range start. Write target_address
// only while the block is idle.
module rip_relative_lea_reference_scan (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // byte stream
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [7:0]                            req_data_byte,
   input  wire logic [riplea_pkg::FieldWidth-1:0]     req_byte_address,
   input  wire logic                                  req_first_of_range,
   input  wire logic                                  req_range_executable,
   input  wire logic                                  req_last_of_scan,
   // scan report
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [1:0]                                 rsp_match_status,
   output logic [riplea_pkg::FieldWidth-1:0]          rsp_match_address,
   // configuration
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [riplea_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  wire logic [riplea_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [riplea_pkg::CsrDataWidth-1:0]        csr_prdata,
   output logic                                       csr_pready
);

   localparam int AW = riplea_pkg::AddrWidth;

   logic [riplea_pkg::FieldWidth-1:0]     target_ff;
   logic                                  s1_valid_ff;
   riplea_pkg::word_type                  s1_word_ff;
   riplea_pkg::window_type                window_ff, window_in;
   logic [riplea_pkg::RunWidth-1:0]       run_ff, run_in, run_eff;
   logic [1:0]                            count_ff, count_in, count_new;
   logic [AW-1:0]                         found_ff, found_in, found_new;
   logic                                  rsp_valid_ff;
   riplea_pkg::match_status_type          rsp_status_ff, rsp_status_in;
   logic [riplea_pkg::FieldWidth-1:0]     rsp_address_ff, rsp_address_in;
   logic                                  s1_advance;
   logic                                  cand_hit;
   logic                                  hit;
   logic                                  csr_write;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[3] == riplea_pkg::CsrTargetIdx);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_write) begin
         target_ff <= csr_pwdata[riplea_pkg::FieldWidth-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[3] == riplea_pkg::CsrTargetIdx) begin
         csr_prdata = {{(riplea_pkg::CsrDataWidth - riplea_pkg::FieldWidth){1'b0}}, target_ff};
      end
   end

   // scan stage stalls only when a report would overwrite one still waiting
   assign s1_advance = s1_valid_ff && !(s1_word_ff.last_of_scan && rsp_valid_ff && !rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_word_ff.data_byte        <= req_data_byte;
         s1_word_ff.byte_address     <= req_byte_address[AW-1:0];
         s1_word_ff.first_of_range   <= req_first_of_range;
         s1_word_ff.range_executable <= req_range_executable;
         s1_word_ff.last_of_scan     <= req_last_of_scan;
      end
   end

   // candidate check
   riplea_match u_match (
      .window_bytes   (window_ff),
      .cur_byte       (s1_word_ff.data_byte),
      .cur_address    (s1_word_ff.byte_address),
      .target_address (target_ff[AW-1:0]),
      .hit            (cand_hit)
   );

   // scan state update
   always_comb begin
      run_eff   = s1_word_ff.first_of_range ? '0 : run_ff;
      hit       = (run_eff == riplea_pkg::RunWidth'(riplea_pkg::WindowDepth)) &&
                  s1_word_ff.range_executable && cand_hit;
      count_new = count_ff;
      found_new = found_ff;
      if (hit) begin
         if (count_ff == 2'd0) begin
            found_new = s1_word_ff.byte_address - AW'(riplea_pkg::WindowDepth);
         end
         if (count_ff != 2'd2) begin
            count_new = count_ff + 2'd1;
         end
      end

      window_in = {s1_word_ff.data_byte, window_ff[riplea_pkg::WindowDepth-1:1]};
      run_in    = (run_eff == riplea_pkg::RunWidth'(riplea_pkg::WindowDepth)) ?
                  run_eff : run_eff + riplea_pkg::RunWidth'(1);
      count_in  = count_new;
      found_in  = found_new;
      if (s1_word_ff.last_of_scan) begin
         window_in = '0;
         run_in    = '0;
         count_in  = 2'd0;
         found_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= '0;
         count_ff <= 2'd0;
      end else if (s1_advance) begin
         run_ff   <= run_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         window_ff <= window_in;
         found_ff  <= found_in;
      end
   end

   // report word
   always_comb begin
      rsp_status_in  = riplea_pkg::StatusNone;
      rsp_address_in = '0;
      if (count_new == 2'd1) begin
         rsp_status_in  = riplea_pkg::StatusUnique;
         rsp_address_in = riplea_pkg::FieldWidth'(found_new);
      end else if (count_new == 2'd2) begin
         rsp_status_in  = riplea_pkg::StatusAmbiguous;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_word_ff.last_of_scan) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_word_ff.last_of_scan) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_address_ff <= rsp_address_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_status  = rsp_status_ff;
   assign rsp_match_address = rsp_address_ff;

`ifndef SYNTHESIS
   // match count saturates at two
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("match count beyond saturation");

   // end of scan clears the scan state
   a_scan_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_word_ff.last_of_scan) |=> (run_ff == '0 && count_ff == 2'd0))
      else $error("scan state not cleared after report");

   // a report is loaded on the edge after a last word advances
   a_report_load: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_word_ff.last_of_scan) |=> rsp_valid_ff)
      else $error("report missing after last word");

   // input stalls only behind a waiting report
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_word_ff.last_of_scan && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a waiting report");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_rip_relative_lea_reference_scan.sv @@
// tb_rip_relative_lea_reference_scan: self-checking bench for the lea reference scanner,
// with a byte driver, a report monitor and a cycle-free predictor of the scan reports
// depends on riplea_pkg and rip_relative_lea_reference_scan
`timescale 1ns / 1ps

module tb_rip_relative_lea_reference_scan;

   typedef struct packed {
      riplea_pkg::match_status_type           status;
      logic [riplea_pkg::FieldWidth-1:0]      address;
   } scan_report_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // byte stream
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [7:0]                          req_data_byte = '0;
   logic [riplea_pkg::FieldWidth-1:0]   req_byte_address = '0;
   logic                                req_first_of_range = 1'b0;
   logic                                req_range_executable = 1'b0;
   logic                                req_last_of_scan = 1'b0;

   // scan report
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [1:0]                          rsp_match_status;
   logic [riplea_pkg::FieldWidth-1:0]   rsp_match_address;

   // configuration
   logic                                  csr_psel = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite = 1'b0;
   logic [riplea_pkg::CsrAddrWidth-1:0]   csr_paddr = '0;
   logic [riplea_pkg::CsrDataWidth-1:0]   csr_pwdata = '0;
   logic [riplea_pkg::CsrDataWidth-1:0]   csr_prdata;
   logic                                  csr_pready;

   // words waiting to be sent and reports still owed by the block
   riplea_pkg::word_type pending_words[$];
   scan_report_type      due_reports[$];
   int                   error_count = 0;

   // predictor state
   logic [riplea_pkg::AddrWidth-1:0] lea_target = '0;
   logic [7:0]                       tail_bytes [riplea_pkg::WindowDepth];
   int                               tail_fill = 0;
   int                               hit_count = 0;
   logic [riplea_pkg::AddrWidth-1:0] first_hit_addr = '0;

   // generator state
   logic [riplea_pkg::AddrWidth-1:0] gen_addr = '0;
   logic                             gen_first = 1'b0;
   logic                             gen_exec = 1'b0;
   bit                               gen_noisy = 1'b0;
   int                               gen_left = 0;
   int                               words_made = 0;

   // receiver hold-off
   bit   hold_go = 1'b0;
   logic rx_hold = 1'b0;

   rip_relative_lea_reference_scan uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_byte_address     (req_byte_address),
      .req_first_of_range   (req_first_of_range),
      .req_range_executable (req_range_executable),
      .req_last_of_scan     (req_last_of_scan),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_match_status     (rsp_match_status),
      .rsp_match_address    (rsp_match_address),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // predictor

   task automatic clear_scan_state();
      int k;
      for (k = 0; k < riplea_pkg::WindowDepth; k++) tail_bytes[k] = 8'h00;
      tail_fill = 0;
      hit_count = 0;
      first_hit_addr = '0;
   endtask

   // take one word into the window, owe a report on the last word of a scan
   task automatic scan_word(input riplea_pkg::word_type w);
      logic [31:0]                      disp;
      logic [riplea_pkg::AddrWidth-1:0] dest;
      bit                               hit;
      scan_report_type                  rep;
      int                               k;
      if (w.first_of_range) tail_fill = 0;
      disp = {w.data_byte, tail_bytes[5], tail_bytes[4], tail_bytes[3]};
      dest = w.byte_address + riplea_pkg::AddrWidth'(1)
           + {{(riplea_pkg::AddrWidth-32){disp[31]}}, disp};
      hit = (tail_bytes[0] == riplea_pkg::PrefixRexW || tail_bytes[0] == riplea_pkg::PrefixRexWR)
         && tail_bytes[1] == riplea_pkg::OpcodeLea
         && (tail_bytes[2] & riplea_pkg::ModrmMask) == riplea_pkg::ModrmRipRel
         && dest == lea_target;
      if (tail_fill >= riplea_pkg::WindowDepth && w.range_executable && hit) begin
         if (hit_count == 0) first_hit_addr = w.byte_address - riplea_pkg::AddrWidth'(6);
         if (hit_count < 2) hit_count++;
      end
      for (k = 0; k < riplea_pkg::WindowDepth - 1; k++) tail_bytes[k] = tail_bytes[k+1];
      tail_bytes[riplea_pkg::WindowDepth-1] = w.data_byte;
      if (tail_fill < riplea_pkg::WindowDepth) tail_fill++;
      if (w.last_of_scan) begin
         if (hit_count == 1) begin
            rep.status = riplea_pkg::StatusUnique;
            rep.address = first_hit_addr;
         end else begin
            rep.status = (hit_count >= 2) ? riplea_pkg::StatusAmbiguous
                                          : riplea_pkg::StatusNone;
            rep.address = '0;
         end
         due_reports.push_back(rep);
         clear_scan_state();
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // checking

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
   endfunction

   function automatic void check_report();
      scan_report_type rep;
      if (due_reports.size() == 0) begin
         flag_error($sformatf("report with none owed: status %0d address %h",
                              rsp_match_status, rsp_match_address));
      end else begin
         rep = due_reports.pop_front();
         if (rsp_match_status !== rep.status || rsp_match_address !== rep.address)
            flag_error($sformatf("report mismatch: status exp %0d got %0d, address exp %h got %h",
                                 rep.status, rsp_match_status, rep.address, rsp_match_address));
      end
   endfunction

   // gap before the next word or report, with spells of back-to-back traffic
   function automatic int unsigned next_gap(inout bit calm);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 4);
   endfunction

   // ---------------------------------------------------------------------------------------
   // byte driver

   riplea_pkg::word_type offer_word;
   int unsigned          send_gap = 0;
   bit                   tx_calm = 1'b0;

   always @(posedge clock) begin
      bit offering;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offering = req_valid;
         if (req_valid && req_ready) begin
            scan_word(offer_word);
            offering = 1'b0;
            send_gap = next_gap(tx_calm);
         end else if (!offering && send_gap > 0) begin
            send_gap--;
         end
         if (!offering && send_gap == 0 && pending_words.size() > 0) begin
            offer_word = pending_words.pop_front();
            req_data_byte <= offer_word.data_byte;
            req_byte_address <= offer_word.byte_address;
            req_first_of_range <= offer_word.first_of_range;
            req_range_executable <= offer_word.range_executable;
            req_last_of_scan <= offer_word.last_of_scan;
            offering = 1'b1;
         end
         req_valid <= offering;
      end
   end

   // ---------------------------------------------------------------------------------------
   // report monitor

   int unsigned take_gap = 0;
   bit          rx_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_report();
            take_gap = next_gap(rx_calm);
         end else if (take_gap > 0) begin
            take_gap--;
         end
         rsp_ready <= (take_gap == 0) && !rx_hold;
      end
   end

   // long receiver stall so that reports back up and the input stalls
   initial begin
      wait (hold_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // stimulus generation

   function automatic logic [riplea_pkg::AddrWidth-1:0] pick_base();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1: return r[riplea_pkg::AddrWidth-1:0];
         2: return lea_target + riplea_pkg::AddrWidth'(32'h8000_0000)
                   - riplea_pkg::AddrWidth'($urandom_range(0, 64));
         3: return lea_target - riplea_pkg::AddrWidth'(32'h8000_0000)
                   + riplea_pkg::AddrWidth'($urandom_range(0, 64));
         default: return lea_target + riplea_pkg::AddrWidth'($urandom_range(0, 8192))
                         - riplea_pkg::AddrWidth'(4096);
      endcase
   endfunction

   task automatic new_range(input logic [riplea_pkg::AddrWidth-1:0] base);
      gen_addr = base;
      gen_first = 1'b1;
      gen_exec = ($urandom_range(0, 7) != 0);
   endtask

   task automatic emit(input logic [7:0] b);
      riplea_pkg::word_type w;
      w.data_byte = b;
      w.byte_address = gen_addr;
      w.first_of_range = gen_first;
      w.range_executable = (gen_noisy && $urandom_range(0, 49) == 0) ? !gen_exec : gen_exec;
      w.last_of_scan = (gen_left == 1);
      pending_words.push_back(w);
      gen_addr = gen_addr + riplea_pkg::AddrWidth'(1);
      // occasional address jump inside a range
      if (gen_noisy && $urandom_range(0, 199) == 0)
         gen_addr = gen_addr + riplea_pkg::AddrWidth'($urandom_range(1, 300));
      gen_first = 1'b0;
      gen_left--;
      words_made++;
   endtask

   // lea aimed at the target, sometimes spoilt in one spot
   task automatic emit_lea(input bit clean);
      logic [7:0]                       code [7];
      logic [riplea_pkg::AddrWidth-1:0] rel;
      int                               flaw;
      int                               cut;
      int                               k;
      rel = lea_target - (gen_addr + riplea_pkg::AddrWidth'(7));
      code[0] = $urandom_range(0, 1) ? riplea_pkg::PrefixRexW : riplea_pkg::PrefixRexWR;
      code[1] = riplea_pkg::OpcodeLea;
      code[2] = {2'b00, 3'($urandom_range(0, 7)), 3'b101};
      code[3] = rel[7:0];
      code[4] = rel[15:8];
      code[5] = rel[23:16];
      code[6] = rel[31:24];
      flaw = (!clean && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      cut = $urandom_range(1, 6);
      k = $urandom_range(0, 4);
      case (flaw)
         1: code[0] = code[0] ^ (8'h01 << $urandom_range(0, 7));
         2: code[1] = code[1] ^ (8'h01 << $urandom_range(0, 7));
         3: code[2] = code[2] ^ (8'h01 << ((k < 3) ? k : k + 3));
         4: code[3 + $urandom_range(0, 3)] ^= (8'h01 << $urandom_range(0, 7));
         default: ;
      endcase
      for (k = 0; k < 7 && gen_left > 0; k++) begin
         // range restart in the middle of the instruction
         if (flaw == 5 && k == cut) gen_first = 1'b1;
         emit(code[k]);
      end
   endtask

   task automatic gen_scan(input int len);
      gen_left = len;
      new_range(pick_base());
      while (gen_left > 0) begin
         if (!gen_first && $urandom_range(0, 39) == 0) new_range(pick_base());
         if ($urandom_range(0, 5) == 0) begin
            emit_lea(1'b0);
         end else if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
               0: emit(riplea_pkg::PrefixRexW);
               1: emit(riplea_pkg::PrefixRexWR);
               2: emit(riplea_pkg::OpcodeLea);
               default: emit(riplea_pkg::ModrmRipRel);
            endcase
         end else begin
            emit(8'($urandom));
         end
      end
   endtask

   task automatic gen_phase(input int count, input int max_len);
      int goal;
      goal = words_made + count;
      while (words_made < goal)
         gen_scan(($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, max_len));
   endtask

   // ---------------------------------------------------------------------------------------
   // register write and idle wait

   task automatic write_target(input logic [riplea_pkg::AddrWidth-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= riplea_pkg::CsrAddrWidth'(riplea_pkg::CsrTargetIdx) << 3;
      csr_pwdata <= riplea_pkg::CsrDataWidth'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      lea_target = value;
      @(negedge clock);
   endtask

   // all words sent, all reports in, then a wait for the pipeline to settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || due_reports.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // test sequence

   initial begin
      logic [63:0] r;
      int          p;
      clear_scan_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed scans
      write_target(48'h0000_0000_1234);
      // single-word scan at the top of the address space
      gen_left = 1;
      new_range({riplea_pkg::AddrWidth{1'b1}});
      gen_exec = 1'b1;
      emit(8'hFF);
      // lea wrapping through address zero, matched on the last word,
      // executable only on its seventh byte
      gen_left = 7;
      new_range(48'hFFFF_FFFF_FFFD);
      gen_exec = 1'b0;
      emit(riplea_pkg::PrefixRexWR);
      emit(riplea_pkg::OpcodeLea);
      emit(8'h3D);
      emit(8'h30);
      emit(8'h12);
      emit(8'h00);
      gen_exec = 1'b1;
      emit(8'h00);
      // broken lea head cut off by a range start, then two matches
      gen_left = 17;
      new_range(48'h0000_0000_2000);
      gen_exec = 1'b1;
      emit(riplea_pkg::PrefixRexW);
      emit(riplea_pkg::OpcodeLea);
      emit(riplea_pkg::ModrmRipRel);
      gen_first = 1'b1;
      emit_lea(1'b1);
      emit_lea(1'b1);
      wait_idle();

      // random scans, short ones first while the receiver stalls
      gen_noisy = 1'b1;
      write_target('0);
      hold_go = 1'b1;
      gen_phase(300, 8);
      wait_idle();
      write_target({riplea_pkg::AddrWidth{1'b1}});
      gen_phase(400, 30);
      wait_idle();
      for (p = 0; p < 2; p++) begin
         r = {$urandom, $urandom};
         write_target(r[riplea_pkg::AddrWidth-1:0]);
         gen_phase(400, 30);
         wait_idle();
      end

      if (due_reports.size() != 0) flag_error("reports still owed at end of run");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ rip_relative_lea_reference_scan.f @@
rtl/riplea_pkg.sv
rtl/riplea_match.sv
rtl/rip_relative_lea_reference_scan.sv
tb/sv/tb_rip_relative_lea_reference_scan.sv
